FILE: rtl/fdtd_pkg.sv
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared types, constants and helpers for the 1-D Yee field update block.
// ----------------------------------------------------------------------------
package fdtd_pkg;

    localparam int CELLS_DEF = 1024;
    localparam int FIELD_W   = 32;
    localparam int COEF_W    = 48;
    localparam int USE_W     = 11;
    localparam int CELL_W    = 10;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 48;

    localparam logic [USE_W-1:0]         USE_RST   = 11'd1024;
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 48'sh0001_0000_0000;
    localparam logic signed [FIELD_W-1:0] FIELD_MAX = 32'sh7fff_ffff;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IW-1:0] {
        REG_CELLS_IN_USE = 3'd0,
        REG_SOURCE_CELL  = 3'd1,
        REG_PROBE_CELL   = 3'd2,
        REG_E_DECAY      = 3'd3,
        REG_E_CURL_GAIN  = 3'd4,
        REG_H_DECAY      = 3'd5,
        REG_H_CURL_GAIN  = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        TERM_E_DECAY = 2'd0,
        TERM_E_CURL  = 2'd1,
        TERM_H_DECAY = 2'd2,
        TERM_H_CURL  = 2'd3
    } term_t;

    typedef struct packed {
        logic  clr_wr;
        logic  take_in;
        logic  rd0;
        logic  ld0;
        logic  rd_nx;
        logic  ld_nx;
        logic  mul_a;
        logic  mul_b;
        logic  mul_c;
        logic  mul_d;
        logic  mul_e;
        term_t term;
        logic  e_fin;
        logic  h_fin;
        logic  probe_rd;
        logic  probe_ld;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic loop_last;
        logic clr_last;
        logic out_free;
    } sts_t;

    // clamp a 33-bit sum to the field range
    function automatic logic signed [FIELD_W-1:0] sat33(input logic signed [FIELD_W:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v[FIELD_W] != v[FIELD_W-1])
        begin
            r = v[FIELD_W] ? FIELD_MIN : FIELD_MAX;
        end
        else
        begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/fdtd_ram.sv
// ----------------------------------------------------------------------------
// fdtd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fdtd_dp.sv
// ----------------------------------------------------------------------------
// fdtd_dp
// Datapath: configuration registers, field stores, shared coefficient
// multiplier with rounding and saturation, probe output register.
// ----------------------------------------------------------------------------
module fdtd_dp #(
    parameter int CELLS = fdtd_pkg::CELLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fdtd_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [fdtd_pkg::CFG_DW-1:0]         cfg_data,
    input  logic signed [fdtd_pkg::FIELD_W-1:0] source_value,
    input  logic                                out_stall,
    input  fdtd_pkg::cmd_t                      cmd,
    output fdtd_pkg::sts_t                      sts,
    output logic                                out_valid,
    output logic signed [fdtd_pkg::FIELD_W-1:0] e_probe,
    output logic signed [fdtd_pkg::FIELD_W-1:0] h_probe
);

    localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW0 = $clog2(CELLS + 1);
    localparam int NW  = (NW0 > fdtd_pkg::USE_W) ? NW0 : fdtd_pkg::USE_W;
    localparam int FW  = fdtd_pkg::FIELD_W;
    localparam int CW  = fdtd_pkg::COEF_W;
    localparam int QW  = 50;

    // configuration
    logic [fdtd_pkg::USE_W-1:0]  use_reg;
    logic [fdtd_pkg::CELL_W-1:0] src_cell_reg;
    logic [fdtd_pkg::CELL_W-1:0] probe_cell_reg;
    logic signed [CW-1:0]        e_decay_reg;
    logic signed [CW-1:0]        e_curl_reg;
    logic signed [CW-1:0]        h_decay_reg;
    logic signed [CW-1:0]        h_curl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg        <= fdtd_pkg::USE_RST;
            src_cell_reg   <= '0;
            probe_cell_reg <= '0;
            e_decay_reg    <= fdtd_pkg::COEF_ONE;
            e_curl_reg     <= '0;
            h_decay_reg    <= fdtd_pkg::COEF_ONE;
            h_curl_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (fdtd_pkg::reg_idx_t'(cfg_index))
                fdtd_pkg::REG_CELLS_IN_USE: use_reg <= cfg_data[fdtd_pkg::USE_W-1:0];
                fdtd_pkg::REG_SOURCE_CELL:  src_cell_reg <= cfg_data[fdtd_pkg::CELL_W-1:0];
                fdtd_pkg::REG_PROBE_CELL:   probe_cell_reg <= cfg_data[fdtd_pkg::CELL_W-1:0];
                fdtd_pkg::REG_E_DECAY:      e_decay_reg <= cfg_data[CW-1:0];
                fdtd_pkg::REG_E_CURL_GAIN:  e_curl_reg <= cfg_data[CW-1:0];
                fdtd_pkg::REG_H_DECAY:      h_decay_reg <= cfg_data[CW-1:0];
                fdtd_pkg::REG_H_CURL_GAIN:  h_curl_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // active cell count, clamped to the store depth
    logic [NW-1:0] n_cells;
    logic [NW-1:0] src_ext;
    logic [NW-1:0] probe_ext;
    logic [NW-1:0] m_plus_ext;

    logic [AW-1:0] m_reg;
    logic [AW-1:0] m_plus;

    assign n_cells    = (NW'(use_reg) > NW'(CELLS)) ? NW'(CELLS) : NW'(use_reg);
    assign src_ext    = NW'(src_cell_reg);
    assign probe_ext  = NW'(probe_cell_reg);
    assign m_plus     = m_reg + AW'(1);
    assign m_plus_ext = NW'(m_reg) + NW'(1);

    assign sts.n_zero    = (n_cells == '0);
    assign sts.n_one     = (n_cells == NW'(1));
    assign sts.loop_last = ((NW+1)'(m_reg) + (NW+1)'(2)) >= (NW+1)'(n_cells);
    assign sts.clr_last  = (m_reg == AW'(CELLS - 1));

    logic src_at0;
    logic src_at_nx;
    logic probe_in;

    assign src_at0   = (src_ext == '0);
    assign src_at_nx = (src_ext == m_plus_ext);
    assign probe_in  = (probe_ext < n_cells);

    // field stores
    logic          e_wr_en;
    logic          h_wr_en;
    logic [AW-1:0] e_wr_addr;
    logic [AW-1:0] h_wr_addr;
    logic [FW-1:0] e_wr_data;
    logic [FW-1:0] h_wr_data;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] e_rd_raw;
    logic [FW-1:0] h_rd_raw;
    logic signed [FW-1:0] e_rd;
    logic signed [FW-1:0] h_rd;

    assign e_rd = e_rd_raw;
    assign h_rd = h_rd_raw;

    fdtd_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_e_ram (
        .clk     (clk),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_addr (rd_addr),
        .rd_data (e_rd_raw)
    );

    fdtd_ram #(.WIDTH(FW), .DEPTH(CELLS)) u_h_ram (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_addr (rd_addr),
        .rd_data (h_rd_raw)
    );

    // cell registers
    logic signed [FW-1:0] src_reg;
    logic signed [FW-1:0] e_m_reg;
    logic signed [FW-1:0] h_m_reg;
    logic signed [FW-1:0] e_old_nx_reg;
    logic signed [FW-1:0] h_nx_reg;
    logic signed [FW-1:0] e_nx_new_reg;
    logic signed [FW:0]   acc_reg;

    logic signed [FW-1:0] e0_val;
    logic signed [FW-1:0] e_upd;
    logic signed [FW-1:0] e_fin_val;
    logic signed [FW-1:0] h_fin_val;

    assign e0_val    = src_at0 ? fdtd_pkg::sat33({e_rd[FW-1], e_rd} - {src_reg[FW-1], src_reg})
                               : e_rd;
    assign e_upd     = fdtd_pkg::sat33(acc_reg);
    // source lands after the curl update of its cell
    assign e_fin_val = src_at_nx ? fdtd_pkg::sat33({e_upd[FW-1], e_upd}
                                                   - {src_reg[FW-1], src_reg})
                                 : e_upd;
    assign h_fin_val = fdtd_pkg::sat33(acc_reg);

    always_comb
    begin
        rd_addr = probe_ext[AW-1:0];
        if (cmd.rd0)
        begin
            rd_addr = '0;
        end
        else if (cmd.rd_nx)
        begin
            rd_addr = m_plus;
        end

        e_wr_en   = 1'b0;
        e_wr_addr = m_reg;
        e_wr_data = '0;
        h_wr_en   = 1'b0;
        h_wr_addr = m_reg;
        h_wr_data = '0;
        if (cmd.clr_wr)
        begin
            e_wr_en = 1'b1;
            h_wr_en = 1'b1;
        end
        else if (cmd.ld0)
        begin
            e_wr_en   = src_at0;
            e_wr_addr = '0;
            e_wr_data = e0_val;
        end
        else if (cmd.e_fin)
        begin
            e_wr_en   = 1'b1;
            e_wr_addr = m_plus;
            e_wr_data = e_fin_val;
        end
        else if (cmd.h_fin)
        begin
            h_wr_en   = 1'b1;
            h_wr_data = h_fin_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else if (cmd.take_in)
        begin
            m_reg <= '0;
        end
        else if (cmd.clr_wr || cmd.h_fin)
        begin
            m_reg <= m_plus;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            src_reg <= source_value;
        end
        if (cmd.ld0)
        begin
            e_m_reg <= e0_val;
            h_m_reg <= h_rd;
        end
        if (cmd.ld_nx)
        begin
            e_old_nx_reg <= e_rd;
            h_nx_reg     <= h_rd;
        end
        if (cmd.e_fin)
        begin
            e_nx_new_reg <= e_fin_val;
        end
        if (cmd.h_fin)
        begin
            h_m_reg <= h_nx_reg;
            e_m_reg <= e_nx_new_reg;
        end
    end

    // shared coefficient multiplier: magnitudes, two partial products,
    // rounded sum, then sign, clamp and accumulate
    logic signed [CW-1:0]  coef_sel;
    logic signed [FW+1:0]  x_sel;
    logic [CW-1:0]         a_mag;
    logic [FW+1:0]         x_mag;
    logic [CW-1:0]         a_reg;
    logic [FW:0]           b_reg;
    logic                  neg_reg;
    logic [63:0]           p0_reg;
    logic [47:0]           p1_reg;
    logic [QW-1:0]         q_reg;
    logic [QW-1:0]         q_sum;
    logic signed [FW-1:0]  term_val;

    always_comb
    begin
        case (cmd.term)
            fdtd_pkg::TERM_E_DECAY:
            begin
                coef_sel = e_decay_reg;
                x_sel    = (FW+2)'(e_old_nx_reg);
            end
            fdtd_pkg::TERM_E_CURL:
            begin
                coef_sel = e_curl_reg;
                x_sel    = (FW+2)'(h_m_reg) - (FW+2)'(h_nx_reg);
            end
            fdtd_pkg::TERM_H_DECAY:
            begin
                coef_sel = h_decay_reg;
                x_sel    = (FW+2)'(h_m_reg);
            end
            fdtd_pkg::TERM_H_CURL:
            begin
                coef_sel = h_curl_reg;
                x_sel    = (FW+2)'(e_m_reg) - (FW+2)'(e_nx_new_reg);
            end
            default:
            begin
                coef_sel = e_decay_reg;
                x_sel    = '0;
            end
        endcase
    end

    assign a_mag = coef_sel[CW-1] ? (CW'(0) - coef_sel) : coef_sel;
    assign x_mag = x_sel[FW+1] ? ((FW+2)'(0) - x_sel) : x_sel;

    assign q_sum = QW'((p0_reg + 64'h0000_0000_8000_0000) >> 32)
                 + QW'(p1_reg)
                 + (b_reg[FW] ? QW'(a_reg[31:0]) : QW'(0))
                 + (b_reg[FW] ? QW'({a_reg[CW-1:32], 32'h0}) : QW'(0));

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > QW'(32'h8000_0000))
            begin
                term_val = fdtd_pkg::FIELD_MIN;
            end
            else
            begin
                term_val = FW'(QW'(0) - q_reg);
            end
        end
        else
        begin
            if (q_reg > QW'(32'h7fff_ffff))
            begin
                term_val = fdtd_pkg::FIELD_MAX;
            end
            else
            begin
                term_val = q_reg[FW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a)
        begin
            neg_reg <= coef_sel[CW-1] ^ x_sel[FW+1];
            a_reg   <= a_mag;
            b_reg   <= x_mag[FW:0];
        end
        if (cmd.mul_b)
        begin
            p0_reg <= a_reg[31:0] * b_reg[31:0];
        end
        if (cmd.mul_c)
        begin
            p1_reg <= a_reg[CW-1:32] * b_reg[31:0];
        end
        if (cmd.mul_d)
        begin
            q_reg <= q_sum;
        end
        if (cmd.mul_e)
        begin
            if (cmd.term == fdtd_pkg::TERM_E_DECAY || cmd.term == fdtd_pkg::TERM_H_DECAY)
            begin
                acc_reg <= (FW+1)'(term_val);
            end
            else
            begin
                acc_reg <= (FW+1)'(term_val) + acc_reg;
            end
        end
    end

    // result register
    logic                 out_valid_reg;
    logic signed [FW-1:0] e_probe_reg;
    logic signed [FW-1:0] h_probe_reg;

    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.probe_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_ld)
        begin
            e_probe_reg <= probe_in ? e_rd : '0;
            h_probe_reg <= probe_in ? h_rd : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign e_probe   = e_probe_reg;
    assign h_probe   = h_probe_reg;

endmodule

FILE: rtl/fdtd_ctrl.sv
// ----------------------------------------------------------------------------
// fdtd_ctrl
// Sequencer: store clearing, per-cell E then H update, probe readout.
// ----------------------------------------------------------------------------
module fdtd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  fdtd_pkg::sts_t sts,
    output logic           idle,
    output fdtd_pkg::cmd_t cmd
);

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000_0000_0000_0001,
        S_IDLE     = 15'b000_0000_0000_0010,
        S_RD0      = 15'b000_0000_0000_0100,
        S_LD0      = 15'b000_0000_0000_1000,
        S_RD_NX    = 15'b000_0000_0001_0000,
        S_LD_NX    = 15'b000_0000_0010_0000,
        S_MUL_A    = 15'b000_0000_0100_0000,
        S_MUL_B    = 15'b000_0000_1000_0000,
        S_MUL_C    = 15'b000_0001_0000_0000,
        S_MUL_D    = 15'b000_0010_0000_0000,
        S_MUL_E    = 15'b000_0100_0000_0000,
        S_E_FIN    = 15'b000_1000_0000_0000,
        S_H_FIN    = 15'b001_0000_0000_0000,
        S_PROBE_RD = 15'b010_0000_0000_0000,
        S_PROBE_LD = 15'b100_0000_0000_0000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    fdtd_pkg::term_t term_reg;
    fdtd_pkg::term_t term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            term_reg  <= fdtd_pkg::TERM_E_DECAY;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = sts.n_zero ? S_PROBE_RD : S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = S_LD0;
            end
            S_LD0:
            begin
                cmd.ld0    = 1'b1;
                state_next = sts.n_one ? S_PROBE_RD : S_RD_NX;
            end
            S_RD_NX:
            begin
                cmd.rd_nx  = 1'b1;
                state_next = S_LD_NX;
            end
            S_LD_NX:
            begin
                cmd.ld_nx  = 1'b1;
                term_next  = fdtd_pkg::TERM_E_DECAY;
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.mul_c  = 1'b1;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.mul_d  = 1'b1;
                state_next = S_MUL_E;
            end
            S_MUL_E:
            begin
                cmd.mul_e = 1'b1;
                if (term_reg == fdtd_pkg::TERM_E_CURL)
                begin
                    state_next = S_E_FIN;
                end
                else if (term_reg == fdtd_pkg::TERM_H_CURL)
                begin
                    state_next = S_H_FIN;
                end
                else
                begin
                    term_next  = fdtd_pkg::term_t'(term_reg + 2'd1);
                    state_next = S_MUL_A;
                end
            end
            S_E_FIN:
            begin
                cmd.e_fin  = 1'b1;
                term_next  = fdtd_pkg::TERM_H_DECAY;
                state_next = S_MUL_A;
            end
            S_H_FIN:
            begin
                cmd.h_fin  = 1'b1;
                state_next = sts.loop_last ? S_PROBE_RD : S_RD_NX;
            end
            S_PROBE_RD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PROBE_LD;
            end
            S_PROBE_LD:
            begin
                // hold until the result register can take the new result
                if (sts.out_free)
                begin
                    cmd.probe_ld = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/fdtd_1d_yee_field_update_top.sv
// ----------------------------------------------------------------------------
// fdtd_1d_yee_field_update_top
// One-dimensional Yee field update, one time tick per request.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  source_value
//   out      output     out_valid / out_stall e_probe, h_probe
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A tick walks through the n active cells in turn; each cell
// runs four coefficient products through one shared 48x33-bit multiplier at
// five steps each, plus a read, an E write-back and an H write-back.
// After reset a clearing pass zeroes both stores; no request is taken during it.
// A finished result waits in the output register while the next request
// is taken; a stalled output only holds the block in its last step.
// ----------------------------------------------------------------------------
module fdtd_1d_yee_field_update_top #(
    parameter int CELLS = fdtd_pkg::CELLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fdtd_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [fdtd_pkg::CFG_DW-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fdtd_pkg::FIELD_W-1:0] source_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fdtd_pkg::FIELD_W-1:0] e_probe,
    output logic signed [fdtd_pkg::FIELD_W-1:0] h_probe
);

    fdtd_pkg::cmd_t cmd;
    fdtd_pkg::sts_t sts;
    logic           idle;

    assign in_stall = !idle;

    fdtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .idle     (idle),
        .cmd      (cmd)
    );

    fdtd_dp #(.CELLS(CELLS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_value (source_value),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .e_probe      (e_probe),
        .h_probe      (h_probe)
    );

    // a taken request starts work at once
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken but block stayed idle");

    // only one read address source at a time
    a_rd_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd0, cmd.rd_nx, cmd.probe_rd}))
        else $error("conflicting store read selects");

    // a new result only comes from a probe load
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.probe_ld))
        else $error("result appeared without probe load");

    // at most one store write-back step per cycle
    a_wb_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ld0, cmd.e_fin, cmd.h_fin, cmd.clr_wr}))
        else $error("overlapping store write steps");

endmodule
